// ===== sv/pwmcf_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmcf_pkg: shared types and constants of the PWM pulse capture filter
// Source codes, register map, reset values and the control word of the
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pwmcf_pkg;

  // Event source codes
  localparam logic [3:0] SRC_SONAR     = 4'd8;
  localparam logic [3:0] SRC_IMU       = 4'd9;
  localparam logic [3:0] HOLD_CHANNEL  = 4'd6;
  localparam logic [3:0] FRAME_CHANNEL = 4'd5;
  localparam logic [3:0] STICK_GROUP   = 4'd4;

  // Register map (index = paddr[4:2])
  localparam int          PADDR_W          = 5;
  localparam int          REG_IDX_W        = 3;
  localparam logic [2:0]  REG_MIN_WIDTH    = 3'd0;
  localparam logic [2:0]  REG_MAX_WIDTH    = 3'd1;
  localparam logic [2:0]  REG_ALPHA_STICK  = 3'd2;
  localparam logic [2:0]  REG_ALPHA_KNOB   = 3'd3;
  localparam logic [2:0]  REG_HOLD_THRESH  = 3'd4;
  localparam logic [2:0]  REG_SONAR_MIN    = 3'd5;
  localparam logic [2:0]  REG_SONAR_MAX    = 3'd6;
  localparam logic [2:0]  REG_SONAR_OFFSET = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_MIN_WIDTH    = 16'd900;
  localparam logic [15:0] RST_MAX_WIDTH    = 16'd2100;
  localparam logic [8:0]  RST_ALPHA        = 9'd128;
  localparam logic [15:0] RST_HOLD_THRESH  = 16'd1500;
  localparam logic [15:0] RST_SONAR_MIN    = 16'd100;
  localparam logic [15:0] RST_SONAR_MAX    = 16'd30000;
  localparam logic [15:0] RST_SONAR_OFFSET = 16'd0;

  // Q8 unity and the largest alpha that takes effect
  localparam logic [8:0]  Q8_ONE = 9'd256;

  // Datapath widths of the shared unit
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 58;
  localparam int FRAC_W  = 24;
  localparam int DIST_W  = ACC_W - FRAC_W;

  typedef enum logic [1:0] {
    ACC_HOLD    = 2'd0,
    ACC_LOAD    = 2'd1,
    ACC_LOAD_HI = 2'd2,
    ACC_ADD     = 2'd3
  } acc_op_e;

  typedef struct packed {
    logic                        mul_en;
    logic signed [MUL_A_W-1:0]   op_a;
    logic signed [MUL_B_W-1:0]   op_b;
    acc_op_e                     acc_op;
  } mac_ctrl_t;

endpackage

// ===== sv/pwmcf_mac.sv =====
// ----------------------------------------------------------------------------
// pwmcf_mac: shared multiply-accumulate unit
// One signed multiplier with a registered product, followed by an
// accumulator that loads, loads shifted by 16, adds or holds.
// ----------------------------------------------------------------------------
module pwmcf_mac
  import pwmcf_pkg::*;
(
  input  logic                      clk_i,
  input  mac_ctrl_t                 ctrl_i,
  output logic signed [MUL_A_W-1:0] prod_lo_o,
  output logic signed [ACC_W-1:0]   acc_o
);

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_d, acc_q;

  // Form the product
  assign op_a   = ctrl_i.op_a;
  assign op_b   = ctrl_i.op_b;
  assign prod_d = op_a * op_b;

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // Accumulate the registered product
  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD:    acc_d = prod_ext;
      ACC_LOAD_HI: acc_d = prod_ext <<< 16;
      ACC_ADD:     acc_d = acc_q + prod_ext;
      default:     acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign prod_lo_o = prod_q[MUL_A_W-1:0];
  assign acc_o     = acc_q;

endmodule

// ===== sv/pwm_pulse_capture_filter_unit.sv =====
// ----------------------------------------------------------------------------
// pwm_pulse_capture_filter_unit: RC pulse width capture with EMA filtering
// A rising edge, IMU event or unknown source ends after the width step, a
// rejected pulse after the window check; an accepted receiver pulse runs on
// through MUL1, MUL2, ACC and UPD, a sonar echo also MUL3. One item at a time:
// no new beat until its result is registered. The sequencer steps all products
// through one shared multiplier and accumulator. Reset clears the capture state
// and loads register defaults at once; the block is ready right after reset.
// ----------------------------------------------------------------------------
module pwm_pulse_capture_filter_unit
  import pwmcf_pkg::*;
#(
  parameter int NUM_CHANNELS    = 8,
  parameter int SONAR_ALPHA_Q8  = 128,
  parameter int SONAR_SCALE_Q16 = 1130
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // event input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3:0]          source_i,
  input  logic                level_i,
  input  logic [31:0]         timestamp_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          source_out_o,
  output logic                accepted_o,
  output logic                rejected_o,
  output logic signed [31:0]  value_o,
  output logic                hold_mode_o,
  output logic [31:0]         frame_count_o,
  output logic [31:0]         sonar_fails_o,
  output logic                imu_ready_o
);

  localparam int RS_DEPTH = NUM_CHANNELS + 1;
  localparam int RS_IDX_W = $clog2(RS_DEPTH);
  localparam int CV_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [RS_IDX_W-1:0] SONAR_IDX = RS_IDX_W'(NUM_CHANNELS);
  localparam logic [4:0] NUM_CH_5 = 5'(NUM_CHANNELS);
  localparam logic signed [MUL_B_W-1:0] SONAR_KEEP  = MUL_B_W'(SONAR_ALPHA_Q8);
  localparam logic signed [MUL_B_W-1:0] SONAR_NEW   = MUL_B_W'(256 - SONAR_ALPHA_Q8);
  localparam logic signed [MUL_B_W-1:0] SONAR_SCALE = MUL_B_W'(SONAR_SCALE_Q16);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WIDTH = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_MUL1  = 8'b0000_1000,
    S_MUL2  = 8'b0001_0000,
    S_MUL3  = 8'b0010_0000,
    S_ACC   = 8'b0100_0000,
    S_UPD   = 8'b1000_0000
  } state_e;

  // S_DONE shares no code with the others; kept as a separate flag state
  state_e state_q, state_d;
  logic   done_q, done_d;

  // configuration registers
  logic [15:0] min_width_q, max_width_q, hold_thresh_q;
  logic [15:0] sonar_min_q, sonar_max_q, sonar_offset_q;
  logic [8:0]  alpha_stick_q, alpha_knob_q;

  // block state
  logic [31:0]        rise_stamp_q [RS_DEPTH];
  logic [15:0]        channel_value_q [NUM_CHANNELS];
  logic signed [31:0] distance_q;
  logic               hold_q;
  logic [31:0]        frames_q, fails_q;

  // item registers
  logic [3:0]              src_q;
  logic                    level_q;
  logic [31:0]             ts_q;
  logic [RS_IDX_W-1:0]     rs_idx_q;
  logic                    is_chan_q, is_sonar_q, is_imu_q;
  logic                    acc_flag_q, rej_flag_q;
  logic [31:0]             w_q;
  logic signed [16:0]      diff_q;

  // result register
  logic                    out_valid_q;
  logic [3:0]              out_src_q;
  logic                    out_acc_q, out_rej_q, out_hold_q, out_imu_q;
  logic signed [31:0]      out_value_q;
  logic [31:0]             out_frames_q, out_fails_q;

  logic                    in_beat, cfg_wr, out_load;
  logic                    is_chan_in, is_sonar_in, is_imu_in;
  logic [CV_IDX_W-1:0]     cv_idx;
  logic [8:0]              alpha_raw, alpha_c;
  logic [15:0]             lo_lim, hi_lim;
  logic                    in_window;
  logic [15:0]             new_value;
  logic signed [DIST_W-1:0] dist_full;
  logic signed [31:0]      dist_sat;
  logic signed [31:0]      value_sel;
  mac_ctrl_t               mac_ctrl;
  logic signed [MUL_A_W-1:0] prod_lo;
  logic signed [ACC_W-1:0] acc;

  // Handshakes
  assign in_ready_o = (state_q == S_IDLE) && !done_q;
  assign in_beat    = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign out_load   = done_q && (!out_valid_q || out_ready_i);

  // Classify the incoming source
  assign is_imu_in   = (source_i == SRC_IMU);
  assign is_sonar_in = (source_i == SRC_SONAR);
  assign is_chan_in  = ({1'b0, source_i} < NUM_CH_5) && !is_imu_in && !is_sonar_in;

  assign cv_idx = CV_IDX_W'(src_q);

  // Pick and clamp the group alpha
  assign alpha_raw = (src_q < STICK_GROUP) ? alpha_stick_q : alpha_knob_q;
  assign alpha_c   = (alpha_raw > Q8_ONE) ? Q8_ONE : alpha_raw;

  // Exclusive width window
  assign lo_lim    = is_sonar_q ? sonar_min_q : min_width_q;
  assign hi_lim    = is_sonar_q ? sonar_max_q : max_width_q;
  assign in_window = (w_q > {16'd0, lo_lim}) && (w_q < {16'd0, hi_lim});

  // Filter results from the accumulator
  assign new_value = acc[FRAC_W-1:8];
  assign dist_full = acc[ACC_W-1:FRAC_W];
  always_comb begin
    if (dist_full[DIST_W-1:31] == '0 || dist_full[DIST_W-1:31] == '1) begin
      dist_sat = dist_full[31:0];
    end else if (dist_full[DIST_W-1]) begin
      dist_sat = 32'sh8000_0000;
    end else begin
      dist_sat = 32'sh7FFF_FFFF;
    end
  end

  // Drive the shared unit from the sequencer
  always_comb begin
    mac_ctrl        = '0;
    mac_ctrl.acc_op = ACC_HOLD;
    case (state_q)
      S_MUL1: begin
        mac_ctrl.mul_en = 1'b1;
        if (is_sonar_q) begin
          mac_ctrl.op_a = {{(MUL_A_W - 32){distance_q[31]}}, distance_q};
          mac_ctrl.op_b = SONAR_KEEP;
        end else begin
          mac_ctrl.op_a = {{(MUL_A_W - 16){1'b0}}, channel_value_q[cv_idx]};
          mac_ctrl.op_b = {{(MUL_B_W - 9){1'b0}}, alpha_c};
        end
      end
      S_MUL2: begin
        mac_ctrl.mul_en = 1'b1;
        if (is_sonar_q) begin
          mac_ctrl.acc_op = ACC_LOAD_HI;
          mac_ctrl.op_a   = {{(MUL_A_W - 17){diff_q[16]}}, diff_q};
          mac_ctrl.op_b   = SONAR_SCALE;
        end else begin
          mac_ctrl.acc_op = ACC_LOAD;
          mac_ctrl.op_a   = {{(MUL_A_W - 16){1'b0}}, w_q[15:0]};
          mac_ctrl.op_b   = {{(MUL_B_W - 9){1'b0}}, Q8_ONE - alpha_c};
        end
      end
      S_MUL3: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.op_a   = prod_lo;
        mac_ctrl.op_b   = SONAR_NEW;
      end
      S_ACC: begin
        mac_ctrl.acc_op = ACC_ADD;
      end
      default: begin
        mac_ctrl.acc_op = ACC_HOLD;
      end
    endcase
  end

  pwmcf_mac u_mac (
    .clk_i     (clk_i),
    .ctrl_i    (mac_ctrl),
    .prod_lo_o (prod_lo),
    .acc_o     (acc)
  );

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    if (done_q) begin
      if (out_load) begin
        done_d = 1'b0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            state_d = S_WIDTH;
          end
        end
        S_WIDTH: begin
          if ((is_chan_q || is_sonar_q) && !level_q) begin
            state_d = S_CHECK;
          end else begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        end
        S_CHECK: begin
          if (in_window) begin
            state_d = S_MUL1;
          end else begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        end
        S_MUL1:  state_d = S_MUL2;
        S_MUL2:  state_d = is_sonar_q ? S_MUL3 : S_ACC;
        S_MUL3:  state_d = S_ACC;
        S_ACC:   state_d = S_UPD;
        S_UPD: begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Latch the input beat, then the pulse width and the offset sonar width
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      src_q    <= source_i;
      level_q  <= level_i;
      ts_q     <= timestamp_i;
      rs_idx_q <= is_sonar_in ? SONAR_IDX : RS_IDX_W'(source_i);
    end
    if (state_q == S_WIDTH) begin
      w_q <= ts_q - rise_stamp_q[rs_idx_q];
    end
    if (state_q == S_CHECK) begin
      diff_q <= $signed({1'b0, w_q[15:0]}) - $signed({1'b0, sonar_offset_q});
    end
  end

  // Update block state and item flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RS_DEPTH; i++) begin
        rise_stamp_q[i] <= '0;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_value_q[i] <= '0;
      end
      distance_q <= '0;
      hold_q     <= 1'b0;
      frames_q   <= '0;
      fails_q    <= '0;
      is_chan_q  <= 1'b0;
      is_sonar_q <= 1'b0;
      is_imu_q   <= 1'b0;
      acc_flag_q <= 1'b0;
      rej_flag_q <= 1'b0;
    end else begin
      if (in_beat) begin
        is_chan_q  <= is_chan_in;
        is_sonar_q <= is_sonar_in;
        is_imu_q   <= is_imu_in;
        acc_flag_q <= 1'b0;
        rej_flag_q <= 1'b0;
      end
      if (state_q == S_WIDTH && (is_chan_q || is_sonar_q) && level_q) begin
        rise_stamp_q[rs_idx_q] <= ts_q;
      end
      if (state_q == S_CHECK) begin
        if (in_window) begin
          acc_flag_q <= 1'b1;
        end else begin
          rej_flag_q <= 1'b1;
          if (is_sonar_q) begin
            fails_q <= fails_q + 32'd1;
          end
        end
      end
      if (state_q == S_UPD) begin
        if (is_sonar_q) begin
          distance_q <= dist_sat;
        end else begin
          channel_value_q[cv_idx] <= new_value;
          if (src_q == HOLD_CHANNEL) begin
            hold_q <= (new_value > hold_thresh_q);
          end
          if (src_q == FRAME_CHANNEL) begin
            frames_q <= frames_q + 32'd1;
          end
        end
      end
    end
  end

  // Select the value reported with the result
  always_comb begin
    if (is_sonar_q) begin
      value_sel = distance_q;
    end else if (is_chan_q) begin
      value_sel = $signed({16'd0, channel_value_q[cv_idx]});
    end else begin
      value_sel = '0;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_src_q    <= src_q;
      out_acc_q    <= acc_flag_q;
      out_rej_q    <= rej_flag_q;
      out_value_q  <= value_sel;
      out_hold_q   <= hold_q;
      out_frames_q <= frames_q;
      out_fails_q  <= fails_q;
      out_imu_q    <= is_imu_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign source_out_o  = out_src_q;
  assign accepted_o    = out_acc_q;
  assign rejected_o    = out_rej_q;
  assign value_o       = out_value_q;
  assign hold_mode_o   = out_hold_q;
  assign frame_count_o = out_frames_q;
  assign sonar_fails_o = out_fails_q;
  assign imu_ready_o   = out_imu_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q    <= RST_MIN_WIDTH;
      max_width_q    <= RST_MAX_WIDTH;
      alpha_stick_q  <= RST_ALPHA;
      alpha_knob_q   <= RST_ALPHA;
      hold_thresh_q  <= RST_HOLD_THRESH;
      sonar_min_q    <= RST_SONAR_MIN;
      sonar_max_q    <= RST_SONAR_MAX;
      sonar_offset_q <= RST_SONAR_OFFSET;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:2])
        REG_MIN_WIDTH:    min_width_q    <= pwdata[15:0];
        REG_MAX_WIDTH:    max_width_q    <= pwdata[15:0];
        REG_ALPHA_STICK:  alpha_stick_q  <= pwdata[8:0];
        REG_ALPHA_KNOB:   alpha_knob_q   <= pwdata[8:0];
        REG_HOLD_THRESH:  hold_thresh_q  <= pwdata[15:0];
        REG_SONAR_MIN:    sonar_min_q    <= pwdata[15:0];
        REG_SONAR_MAX:    sonar_max_q    <= pwdata[15:0];
        REG_SONAR_OFFSET: sonar_offset_q <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_MIN_WIDTH:    prdata = {16'd0, min_width_q};
      REG_MAX_WIDTH:    prdata = {16'd0, max_width_q};
      REG_ALPHA_STICK:  prdata = {23'd0, alpha_stick_q};
      REG_ALPHA_KNOB:   prdata = {23'd0, alpha_knob_q};
      REG_HOLD_THRESH:  prdata = {16'd0, hold_thresh_q};
      REG_SONAR_MIN:    prdata = {16'd0, sonar_min_q};
      REG_SONAR_MAX:    prdata = {16'd0, sonar_max_q};
      REG_SONAR_OFFSET: prdata = {16'd0, sonar_offset_q};
      default:          prdata = '0;
    endcase
  end

  // Checks
  a_acc_rej_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && rejected_o))
    else $error("result beat both accepted and rejected");

  a_imu_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && imu_ready_o) |-> (value_o == 0 && !accepted_o && !rejected_o))
    else $error("IMU result carries a value or a window verdict");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_o)
    else $error("second beat taken while an item is in flight");

  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fails_q != $past(fails_q)) |->
      ($past(state_q) == S_CHECK && $past(is_sonar_q) && $past(!in_window)))
    else $error("sonar failure count moved outside a rejected echo");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !is_sonar_q) |-> (acc[ACC_W-1:FRAC_W] == '0))
    else $error("channel filter result exceeds 16 bits");

endmodule

// ===== tb/pwm_pulse_capture_checker.sv =====
// ----------------------------------------------------------------------------
// pwm_pulse_capture_checker: result predictor and comparator
// Watches the register port, the edge-event channel and the result channel.
// It keeps its own copy of the capture state and the filter settings and
// derives one expected reading per event beat. Each result beat is compared
// field by field with the oldest reading that is still due.
// ----------------------------------------------------------------------------
module pwm_pulse_capture_checker
  import pwmcf_pkg::*;
#(
  parameter int NUM_CHANNELS    = 8,
  parameter int SONAR_ALPHA_Q8  = 128,
  parameter int SONAR_SCALE_Q16 = 1130
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  // edge-event channel
  input  logic               ev_valid_i,
  input  logic               ev_ready_i,
  input  logic [3:0]         ev_source_i,
  input  logic               ev_level_i,
  input  logic [31:0]        ev_stamp_i,
  // result channel
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [3:0]         res_source_i,
  input  logic               res_accepted_i,
  input  logic               res_rejected_i,
  input  logic signed [31:0] res_value_i,
  input  logic               res_hold_i,
  input  logic [31:0]        res_frames_i,
  input  logic [31:0]        res_sonar_fails_i,
  input  logic               res_imu_i,
  // status for the test top
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 readings_o,
  output int                 pulses_taken_o,
  output int                 pulses_refused_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DIST_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint DIST_MIN = -64'sh0000_0000_8000_0000;
  localparam int     CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int     RT_IDX_W = $clog2(NUM_CHANNELS + 1);

  typedef struct packed {
    logic [3:0]  source;
    logic        accepted;
    logic        rejected;
    logic [31:0] value;
    logic        hold_mode;
    logic [31:0] frame_count;
    logic [31:0] sonar_fails;
    logic        imu_ready;
  } capture_reading_t;

  capture_reading_t readings_due[$];
  capture_reading_t head;

  // capture state: one rise time per channel plus the sonar echo
  logic [31:0]        rise_mark [0:NUM_CHANNELS];
  logic [15:0]        filt_val  [0:NUM_CHANNELS-1];
  logic signed [31:0] echo_dist;
  logic               hold_q;
  logic [31:0]        frame_total;
  logic [31:0]        echo_fail_total;

  // filter settings
  logic [15:0] win_lo, win_hi, hold_lvl, echo_lo, echo_hi, echo_off;
  logic [8:0]  a_stick, a_knob;

  int fails, readings, taken, refused;

  assign fail_count_o     = fails;
  assign pending_o        = readings;
  assign pulses_taken_o   = taken;
  assign pulses_refused_o = refused;

  int checked;
  assign readings_o = checked;

  // Apply one edge event to the capture state and queue the reading it gives.
  task automatic capture_edge(input logic [3:0] src, input logic rising,
                              input logic [31:0] ts);
    capture_reading_t    r;
    logic [31:0]         w;
    logic [8:0]          a;
    logic [63:0]         mix;
    logic signed [63:0]  diff, sum, q;
    logic [CH_IDX_W-1:0] ci;
    logic [RT_IDX_W-1:0] ri;
    r = '0;
    r.source = src;
    ci = CH_IDX_W'(src);
    ri = RT_IDX_W'(src);
    if (src == SRC_IMU) begin
      r.imu_ready = 1'b1;
    end else if (src == SRC_SONAR) begin
      if (rising) begin
        rise_mark[NUM_CHANNELS] = ts;
      end else begin
        w = ts - rise_mark[NUM_CHANNELS];
        if (w > echo_lo && w < echo_hi) begin
          // offset, scale to distance and average, rounding toward minus infinity
          diff = $signed({32'd0, w}) - $signed({48'd0, echo_off});
          sum = longint'(echo_dist) * longint'(SONAR_ALPHA_Q8) * 64'sd65536 +
                diff * longint'(SONAR_SCALE_Q16) * longint'(256 - SONAR_ALPHA_Q8);
          q = sum >>> 24;
          if (q > DIST_MAX) q = DIST_MAX;
          if (q < DIST_MIN) q = DIST_MIN;
          echo_dist = q[31:0];
          r.accepted = 1'b1;
          taken++;
        end else begin
          echo_fail_total++;
          r.rejected = 1'b1;
          refused++;
        end
      end
      r.value = echo_dist;
    end else if (src < NUM_CHANNELS) begin
      if (rising) begin
        rise_mark[ri] = ts;
      end else begin
        w = ts - rise_mark[ri];
        if (w > win_lo && w < win_hi) begin
          // pick the group weight, clamp it to unity and blend
          a = (src < STICK_GROUP) ? a_stick : a_knob;
          if (a > Q8_ONE) a = Q8_ONE;
          mix = 64'(filt_val[ci]) * 64'(a) + 64'(w) * 64'(Q8_ONE - a);
          filt_val[ci] = mix[23:8];
          if (src == HOLD_CHANNEL) hold_q = filt_val[ci] > hold_lvl;
          if (src == FRAME_CHANNEL) frame_total++;
          r.accepted = 1'b1;
          taken++;
        end else begin
          r.rejected = 1'b1;
          refused++;
        end
      end
      r.value = {16'd0, filt_val[ci]};
    end
    r.hold_mode   = hold_q;
    r.frame_count = frame_total;
    r.sonar_fails = echo_fail_total;
    readings_due.push_back(r);
    readings++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      readings_due.delete();
      for (int i = 0; i <= NUM_CHANNELS; i++) rise_mark[i] = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) filt_val[i] = '0;
      echo_dist       = '0;
      hold_q          = 1'b0;
      frame_total     = '0;
      echo_fail_total = '0;
      win_lo          = RST_MIN_WIDTH;
      win_hi          = RST_MAX_WIDTH;
      a_stick         = RST_ALPHA;
      a_knob          = RST_ALPHA;
      hold_lvl        = RST_HOLD_THRESH;
      echo_lo         = RST_SONAR_MIN;
      echo_hi         = RST_SONAR_MAX;
      echo_off        = RST_SONAR_OFFSET;
      readings        = 0;
    end else begin
      // compare the result beat with the oldest reading due
      if (res_valid_i && res_ready_i) begin
        if (readings_due.size() == 0) begin
          $error("result beat from source %0d with no event waiting", res_source_i);
          fails++;
        end else begin
          head = readings_due.pop_front();
          readings--;
          checked++;
          check_field("source_out", 32'(head.source), 32'(res_source_i));
          check_field("accepted", 32'(head.accepted), 32'(res_accepted_i));
          check_field("rejected", 32'(head.rejected), 32'(res_rejected_i));
          check_field("value", head.value, res_value_i);
          check_field("hold_mode", 32'(head.hold_mode), 32'(res_hold_i));
          check_field("frame_count", head.frame_count, res_frames_i);
          check_field("sonar_fails", head.sonar_fails, res_sonar_fails_i);
          check_field("imu_ready", 32'(head.imu_ready), 32'(res_imu_i));
        end
      end
      // predict the event beat
      if (ev_valid_i && ev_ready_i) capture_edge(ev_source_i, ev_level_i, ev_stamp_i);
      // track register writes, masked to the register width
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_MIN_WIDTH:    win_lo   = pwdata_i[15:0];
          REG_MAX_WIDTH:    win_hi   = pwdata_i[15:0];
          REG_ALPHA_STICK:  a_stick  = pwdata_i[8:0];
          REG_ALPHA_KNOB:   a_knob   = pwdata_i[8:0];
          REG_HOLD_THRESH:  hold_lvl = pwdata_i[15:0];
          REG_SONAR_MIN:    echo_lo  = pwdata_i[15:0];
          REG_SONAR_MAX:    echo_hi  = pwdata_i[15:0];
          REG_SONAR_OFFSET: echo_off = pwdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_pwm_pulse_capture_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pwm_pulse_capture_filter_unit: test top of the pulse capture filter
// Drives directed edge events at the reset settings, then random pulse trains,
// IMU events, unknown sources and stray edges under several register
// settings and stall patterns. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_pwm_pulse_capture_filter_unit;
  import pwmcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CHANNELS    = 8;
  localparam int SONAR_ALPHA_Q8  = 128;
  localparam int SONAR_SCALE_Q16 = 1130;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 64;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int TAIL_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [3:0]         source_i    = '0;
  logic               level_i     = 1'b0;
  logic [31:0]        timestamp_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [3:0]         source_out_o;
  logic               accepted_o;
  logic               rejected_o;
  logic signed [31:0] value_o;
  logic               hold_mode_o;
  logic [31:0]        frame_count_o;
  logic [31:0]        sonar_fails_o;
  logic               imu_ready_o;

  int fail_count, pending, readings, pulses_taken, pulses_refused;

  int          send_gap_pct = 11;
  int          recv_gap_pct = 50;
  int          events_sent  = 0;
  int          quiet_cycles = 0;
  bit          stall_kick   = 1'b0;
  bit          stall_seen   = 1'b0;
  int          stall_left   = 0;
  logic [15:0] ch_lo = RST_MIN_WIDTH, ch_hi = RST_MAX_WIDTH;
  logic [15:0] echo_lo = RST_SONAR_MIN, echo_hi = RST_SONAR_MAX;
  logic [31:0] clock_now;

  always #4ns clk_i = ~clk_i;

  pwm_pulse_capture_filter_unit #(
    .NUM_CHANNELS    (NUM_CHANNELS),
    .SONAR_ALPHA_Q8  (SONAR_ALPHA_Q8),
    .SONAR_SCALE_Q16 (SONAR_SCALE_Q16)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .source_i      (source_i),
    .level_i       (level_i),
    .timestamp_i   (timestamp_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .source_out_o  (source_out_o),
    .accepted_o    (accepted_o),
    .rejected_o    (rejected_o),
    .value_o       (value_o),
    .hold_mode_o   (hold_mode_o),
    .frame_count_o (frame_count_o),
    .sonar_fails_o (sonar_fails_o),
    .imu_ready_o   (imu_ready_o)
  );

  pwm_pulse_capture_checker #(
    .NUM_CHANNELS    (NUM_CHANNELS),
    .SONAR_ALPHA_Q8  (SONAR_ALPHA_Q8),
    .SONAR_SCALE_Q16 (SONAR_SCALE_Q16)
  ) checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .ev_valid_i        (in_valid_i),
    .ev_ready_i        (in_ready_o),
    .ev_source_i       (source_i),
    .ev_level_i        (level_i),
    .ev_stamp_i        (timestamp_i),
    .res_valid_i       (out_valid_o),
    .res_ready_i       (out_ready_i),
    .res_source_i      (source_out_o),
    .res_accepted_i    (accepted_o),
    .res_rejected_i    (rejected_o),
    .res_value_i       (value_o),
    .res_hold_i        (hold_mode_o),
    .res_frames_i      (frame_count_o),
    .res_sonar_fails_i (sonar_fails_o),
    .res_imu_i         (imu_ready_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .readings_o        (readings),
    .pulses_taken_o    (pulses_taken),
    .pulses_refused_o  (pulses_refused)
  );

  // Result side: random stalls, or a long hold-off when kicked.
  always @(posedge clk_i) begin
    if (stall_kick != stall_seen) begin
      stall_seen = stall_kick;
      stall_left = HOLD_OFF_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_gap_pct);
    end
  end

  // Abort when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one edge event and hold it until the beat is taken.
  task automatic offer_edge(input logic [3:0] src, input logic lvl,
                            input logic [31:0] ts);
    if ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    source_i    <= src;
    level_i     <= lvl;
    timestamp_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    events_sent++;
  endtask

  task automatic pulse(input logic [3:0] src, input logic [31:0] t0,
                       input logic [31:0] w);
    offer_edge(src, 1'b1, t0);
    offer_edge(src, 1'b0, t0 + w);
  endtask

  // Drop valid and hold until every reading has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all registers; unused upper data bits carry junk to test masking.
  task automatic load_settings(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [8:0] a_st, input logic [8:0] a_kn,
                               input logic [15:0] thr, input logic [15:0] s_lo,
                               input logic [15:0] s_hi, input logic [15:0] s_off);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_MIN_WIDTH, {junk[31:16], lo});
    write_reg(REG_MAX_WIDTH, {junk[15:0], hi});
    write_reg(REG_ALPHA_STICK, {junk[31:9], a_st});
    write_reg(REG_ALPHA_KNOB, {junk[22:0], a_kn});
    write_reg(REG_HOLD_THRESH, {junk[23:8], thr});
    write_reg(REG_SONAR_MIN, {junk[27:12], s_lo});
    write_reg(REG_SONAR_MAX, {junk[19:4], s_hi});
    write_reg(REG_SONAR_OFFSET, {junk[30:15], s_off});
    ch_lo   = lo;
    ch_hi   = hi;
    echo_lo = s_lo;
    echo_hi = s_hi;
  endtask

  // Mostly widths inside the window, some on its edges, a few anywhere.
  function automatic logic [31:0] pick_width(input logic [15:0] lo, input logic [15:0] hi);
    int r;
    r = $urandom_range(99, 0);
    if (r < 70 && 32'(hi) > 32'(lo) + 1) return $urandom_range(32'(hi) - 1, 32'(lo) + 1);
    if (r < 90) begin
      case ($urandom_range(3, 0))
        0:       return 32'(lo);
        1:       return 32'(lo) + 1;
        2:       return 32'(hi) - 1;
        default: return 32'(hi);
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int          phase_items;
    int          kind;
    logic [3:0]  src;
    logic [31:0] w;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events at the reset settings
    pulse(4'd0, 32'd0, 32'd1500);
    pulse(4'd1, 32'd100, 32'd900);              // width equal to the lower bound
    pulse(4'd1, 32'd5000, 32'd901);
    pulse(4'd2, 32'hFFFF_FC00, 32'd1536);       // timestamp wraps inside the pulse
    pulse(4'd3, 32'd10000, 32'd2100);           // width equal to the upper bound
    pulse(FRAME_CHANNEL, 32'hFFFF_FFFF, 32'd1500);
    repeat (3) pulse(HOLD_CHANNEL, 32'd40000, 32'd2000);  // third one sets hold mode
    pulse(4'd7, 32'd50000, 32'd2099);
    pulse(SRC_SONAR, 32'd60000, 32'd1000);
    pulse(SRC_SONAR, 32'd70000, 32'd100);
    offer_edge(SRC_SONAR, 1'b0, 32'd0);         // echo fall with no fresh rise
    offer_edge(SRC_IMU, 1'b1, 32'h8000_0000);
    offer_edge(4'd15, 1'b1, 32'd123);
    drain();

    clock_now = $urandom;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 2) begin
        send_gap_pct = 11;
        recv_gap_pct = 50;
      end else if (phase < 4) begin
        send_gap_pct = 50;
        recv_gap_pct = 11;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end

      drain();
      case (phase)
        0: load_settings(RST_MIN_WIDTH, RST_MAX_WIDTH, RST_ALPHA, RST_ALPHA,
                         RST_HOLD_THRESH, RST_SONAR_MIN, RST_SONAR_MAX, RST_SONAR_OFFSET);
        1: load_settings(16'd0, 16'hFFFF, 9'd0, Q8_ONE, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        2: load_settings(16'd1000, 16'd2000, 9'd511, 9'd300, 16'hFFFF, 16'd200,
                         16'd20000, 16'd500);
        default: begin
          logic [15:0] lo, s_lo;
          lo   = 16'($urandom_range(1500, 0));
          s_lo = 16'($urandom_range(500, 0));
          load_settings(lo, lo + 16'($urandom_range(3000, 2)), 9'($urandom_range(511, 0)),
                        9'($urandom_range(511, 0)), 16'($urandom_range(2200, 800)), s_lo,
                        s_lo + 16'($urandom_range(40000, 2)), 16'($urandom_range(65535, 0)));
        end
      endcase

      // long result back-pressure while events keep coming
      if (phase == 4) stall_kick <= ~stall_kick;

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (phase == 2 && phase_items >= PHASE_ITEMS / 2 && phase_items < PHASE_ITEMS / 2 + 2)
          drain();
        kind = $urandom_range(99, 0);
        if (kind < 75) begin
          src       = 4'($urandom_range(8, 0));
          w         = (src == SRC_SONAR) ? pick_width(echo_lo, echo_hi)
                                         : pick_width(ch_lo, ch_hi);
          clock_now = clock_now + $urandom_range(5000, 1);
          pulse(src, clock_now, w);
          clock_now   = clock_now + w;
          phase_items += 2;
        end else if (kind < 85) begin
          offer_edge(SRC_IMU, 1'($urandom_range(1, 0)), $urandom);
          phase_items++;
        end else if (kind < 90) begin
          offer_edge(4'($urandom_range(15, 10)), 1'($urandom_range(1, 0)), $urandom);
        end else begin
          // stray edge: any source, any level, any time
          src = 4'($urandom_range(15, 0));
          offer_edge(src, 1'($urandom_range(1, 0)), $urandom);
          if (src <= SRC_IMU) phase_items++;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d edge events over %0d register settings with stalls on both sides.",
             events_sent, PHASES + 1);
    $display("Checked %0d results: %0d pulses filtered, %0d pulses refused.",
             readings, pulses_taken, pulses_refused);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pwmcf_pkg.sv
sv/pwmcf_mac.sv
sv/pwm_pulse_capture_filter_unit.sv
tb/pwm_pulse_capture_checker.sv
tb/tb_pwm_pulse_capture_filter_unit.sv
